// ===== rtl/grid_raycast_column_renderer_defines.svh =====
// Assertion macros shared by the renderer RTL.
`ifndef GRID_RAYCAST_COLUMN_RENDERER_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_RENDERER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define GRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grc: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define GRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grc: next-cycle check failed");

`endif

// ===== rtl/grc_pkg.sv =====
package grc_pkg;

    localparam int SCREEN_HEIGHT = 40;
    localparam int SCREEN_WIDTH  = 128;   // power of two: ray angle uses a shift
    localparam int MAP_SIZE      = 16;

    localparam int SCREEN_W_LOG  = $clog2(SCREEN_WIDTH);
    localparam int RAY_SHIFT     = SCREEN_W_LOG + 1;
    localparam int RAY_NUM_W     = 24;

    localparam int COORD_W  = 12;
    localparam int ANGLE_W  = 12;
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 6;
    localparam int GLYPH_W  = 4;
    localparam int FOV_W    = 12;
    localparam int DEPTH_W  = 13;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int MAP_BITS = MAP_SIZE * MAP_SIZE;

    localparam int QUEUE_DEPTH_DEF = 2;

    // one map cell in march units (Q8 position times 640, or Q14 per tenth)
    localparam int CELL_STEP = 163840;

    localparam logic [CFG_IDX_W-1:0] CFG_MAP0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOV   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 3'd5;

    localparam logic [CFG_W-1:0]   MAP0_RST  = 64'd9223794255762423807;
    localparam logic [CFG_W-1:0]   MAP1_RST  = 64'd9223794255762391041;
    localparam logic [CFG_W-1:0]   MAP2_RST  = 64'd9223794255762391041;
    localparam logic [CFG_W-1:0]   MAP3_RST  = 64'd18446603342663745537;
    localparam logic [FOV_W-1:0]   FOV_RST   = 12'd512;
    localparam logic [DEPTH_W-1:0] DEPTH_RST = 13'd4096;

    localparam logic [GLYPH_W-1:0] GLYPH_BLANK  = 4'd0;
    localparam logic [GLYPH_W-1:0] GLYPH_FULL   = 4'd1;
    localparam logic [GLYPH_W-1:0] GLYPH_DARK   = 4'd2;
    localparam logic [GLYPH_W-1:0] GLYPH_MEDIUM = 4'd3;
    localparam logic [GLYPH_W-1:0] GLYPH_LIGHT  = 4'd4;
    localparam logic [GLYPH_W-1:0] GLYPH_HASH   = 4'd5;
    localparam logic [GLYPH_W-1:0] GLYPH_X      = 4'd6;
    localparam logic [GLYPH_W-1:0] GLYPH_DOT    = 4'd7;
    localparam logic [GLYPH_W-1:0] GLYPH_DASH   = 4'd8;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [ANGLE_W-1:0] ray;
    } grc_job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } grc_qstat_t;

endpackage

// ===== rtl/grc_if.sv =====
interface grc_cast_if import grc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  pos_x;
    logic [COORD_W-1:0]  pos_y;
    logic [ANGLE_W-1:0]  view_angle;
    logic [COLUMN_W-1:0] column;

    modport source (output valid, pos_x, pos_y, view_angle, column, input ready);
    modport sink   (input valid, pos_x, pos_y, view_angle, column, output ready);
endinterface

interface grc_glyph_if import grc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row;
    logic [GLYPH_W-1:0] glyph;
    logic               last;

    modport source (output valid, row, glyph, last, input ready);
    modport sink   (input valid, row, glyph, last, output ready);
endinterface

// ===== rtl/grid_raycast_column_renderer.sv =====
// channel   dir  word                                    accepted when
// request   in   pos_x, pos_y, view_angle, column        valid && ready
// raster    out  row, glyph, last (one word per row)     valid && ready
// wr_*      in   wr_index, wr_data                       wr_en
//
// Per column: pop the job, sine and cosine on the shared multiplier, seed
// the march, the first unchecked steps, then checked steps (up to 310) and
// the exit, the corner test, the ceiling divider, then SCREEN_HEIGHT rows
// at one a cycle while raster is ready. The front keeps taking words into
// the job queue while the back works, until the queue is full; raster
// stalls hold the back only.
// Reset is asynchronous, active low; no clearing pass.
`include "grid_raycast_column_renderer_defines.svh"

module grid_raycast_column_renderer import grc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    grc_cast_if.sink             request,
    grc_glyph_if.source          raster,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data
);

    logic [CFG_W-1:0]   map0_reg, map0_next;
    logic [CFG_W-1:0]   map1_reg, map1_next;
    logic [CFG_W-1:0]   map2_reg, map2_next;
    logic [CFG_W-1:0]   map3_reg, map3_next;
    logic [FOV_W-1:0]   fov_reg, fov_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;

    logic       push;
    logic       pop;
    grc_job_t   wr_job;
    grc_job_t   rd_job;
    grc_qstat_t qstat;

    // register file; unlisted indexes are dropped
    always_comb
    begin
        map0_next  = map0_reg;
        map1_next  = map1_reg;
        map2_next  = map2_reg;
        map3_next  = map3_reg;
        fov_next   = fov_reg;
        depth_next = depth_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_MAP0:  map0_next  = wr_data;
                CFG_MAP1:  map1_next  = wr_data;
                CFG_MAP2:  map2_next  = wr_data;
                CFG_MAP3:  map3_next  = wr_data;
                CFG_FOV:   fov_next   = wr_data[FOV_W-1:0];
                CFG_DEPTH: depth_next = wr_data[DEPTH_W-1:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map0_reg  <= MAP0_RST;
            map1_reg  <= MAP1_RST;
            map2_reg  <= MAP2_RST;
            map3_reg  <= MAP3_RST;
            fov_reg   <= FOV_RST;
            depth_reg <= DEPTH_RST;
        end
        else
        begin
            map0_reg  <= map0_next;
            map1_reg  <= map1_next;
            map2_reg  <= map2_next;
            map3_reg  <= map3_next;
            fov_reg   <= fov_next;
            depth_reg <= depth_next;
        end
    end

    // front: ray angle per column
    grc_front u_front
    (
        .request       (request),
        .field_of_view (fov_reg),
        .qstat         (qstat),
        .push          (push),
        .job           (wr_job)
    );

    grc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .qstat  (qstat)
    );

    // back: trig, march, corner test, ceiling divide, row emission
    grc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (rd_job),
        .qstat       (qstat),
        .pop         (pop),
        .map_bits    ({map3_reg, map2_reg, map1_reg, map0_reg}),
        .depth_limit (depth_reg),
        .raster      (raster)
    );

    `GRC_ASSERT_NOW(a_last_row, raster.valid && raster.last, raster.row == ROW_W'(SCREEN_HEIGHT - 1))
    `GRC_ASSERT_NEXT(a_row_step, raster.valid && raster.ready && !raster.last, raster.valid && (raster.row == $past(raster.row) + 6'd1))
    `GRC_ASSERT_NOW(a_full_stall, qstat.full, !request.ready && !push)

endmodule

// ===== rtl/grc_front.sv =====
module grc_front import grc_pkg::*;
(
    grc_cast_if.sink           request,
    input  logic [FOV_W-1:0]   field_of_view,
    input  grc_qstat_t         qstat,
    output logic               push,
    output grc_job_t           job
);

    logic [RAY_NUM_W-1:0] base;
    logic [RAY_NUM_W-1:0] fov_w;
    logic [RAY_NUM_W-1:0] col_fov;
    logic [RAY_NUM_W-1:0] num;

    // ray = floor(view - fov/2 + column*fov/W) mod 4096, kept non-negative
    always_comb
    begin
        base    = (RAY_NUM_W'(request.view_angle) << 1) + RAY_NUM_W'(8192);
        base    = base << SCREEN_W_LOG;
        fov_w   = RAY_NUM_W'(field_of_view) << SCREEN_W_LOG;
        col_fov = RAY_NUM_W'(RAY_NUM_W'(request.column) * RAY_NUM_W'(field_of_view)) << 1;
        num     = base - fov_w + col_fov;
    end

    assign request.ready = !qstat.full;
    assign push          = request.valid && !qstat.full;
    assign job.pos_x     = request.pos_x;
    assign job.pos_y     = request.pos_y;
    assign job.ray       = num[RAY_SHIFT +: ANGLE_W];

endmodule

// ===== rtl/grc_queue.sv =====
module grc_queue import grc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  grc_job_t   wr_job,
    input  logic       pop,
    output grc_job_t   rd_job,
    output grc_qstat_t qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    grc_job_t           slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_job;
        end
    end

    assign rd_job      = slot_reg[rd_ptr_reg];
    assign qstat.empty = (count_reg == '0);
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));

endmodule

// ===== rtl/grc_back.sv =====
module grc_back import grc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  grc_job_t            job,
    input  grc_qstat_t          qstat,
    output logic                pop,
    input  logic [MAP_BITS-1:0] map_bits,
    input  logic [DEPTH_W-1:0]  depth_limit,
    grc_glyph_if.source         raster
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SZ    = 5'd1;
    localparam logic [4:0] S_SP    = 5'd2;
    localparam logic [4:0] S_SQ    = 5'd3;
    localparam logic [4:0] S_SS    = 5'd4;
    localparam logic [4:0] S_SE    = 5'd5;
    localparam logic [4:0] S_MINIT = 5'd6;
    localparam logic [4:0] S_MSTEP = 5'd7;
    localparam logic [4:0] S_MCHK  = 5'd8;
    localparam logic [4:0] S_E0    = 5'd9;
    localparam logic [4:0] S_E1    = 5'd10;
    localparam logic [4:0] S_E2    = 5'd11;
    localparam logic [4:0] S_E3    = 5'd12;
    localparam logic [4:0] S_E4    = 5'd13;
    localparam logic [4:0] S_E5    = 5'd14;
    localparam logic [4:0] S_E6    = 5'd15;
    localparam logic [4:0] S_E7    = 5'd16;
    localparam logic [4:0] S_E8    = 5'd17;
    localparam logic [4:0] S_E9    = 5'd18;
    localparam logic [4:0] S_DIV0  = 5'd19;
    localparam logic [4:0] S_DIV   = 5'd20;
    localparam logic [4:0] S_EMIT  = 5'd21;

    localparam int QW   = $clog2(SCREEN_HEIGHT);
    localparam int QI_W = $clog2(QW);
    localparam int DIST_W = 17;

    // march axis: cell index and remainder in CELL_STEP units
    function automatic logic [25:0] step_axis(input logic signed [6:0] n,
                                              input logic signed [18:0] r,
                                              input logic signed [15:0] e);
        logic signed [19:0] s;
        logic signed [6:0]  nn;
        s  = 20'(r) + 20'(e);
        nn = n;
        if (s >= 20'sd163840)
        begin
            s  = s - 20'sd163840;
            nn = n + 7'sd1;
        end
        else if (s < 20'sd0)
        begin
            s  = s + 20'sd163840;
            nn = n - 7'sd1;
        end
        return {nn, s[18:0]};
    endfunction

    function automatic logic off_map(input logic signed [6:0] n,
                                     input logic signed [18:0] r);
        return (n < -7'sd1) || (n == -7'sd1 && r == 19'sd0) || (n >= 7'sd16);
    endfunction

    logic [4:0]               state_reg, state_next;
    grc_job_t                 job_reg, job_next;
    logic                     phase_reg, phase_next;
    logic [14:0]              z2_reg, z2_next;
    logic signed [15:0]       ex_reg, ex_next, ey_reg, ey_next;
    logic signed [6:0]        nx_reg, nx_next, ny_reg, ny_next;
    logic signed [18:0]       rx_reg, rx_next, ry_reg, ry_next;
    logic [8:0]               d10_reg, d10_next;
    logic [3:0]               cellx_reg, cellx_next, celly_reg, celly_next;
    logic [1:0]               far_reg, far_next, k_reg, k_next;
    logic                     edge_reg, edge_next;
    logic signed [28:0]       t1_reg, t1_next, dot_reg, dot_next;
    logic [20:0]              cra_reg, cra_next;
    logic                     big_reg, big_next;
    logic [57:0]              d2_reg, d2_next;
    logic [41:0]              c2_reg, c2_next;
    logic [34:0]              lo_reg, lo_next;
    logic [DIST_W-1:0]        dist_reg, dist_next;
    logic [23:0]              rem_reg, rem_next;
    logic [17:0]              den_reg, den_next;
    logic [QI_W-1:0]          qi_reg, qi_next;
    logic [QW-1:0]            quot_reg, quot_next;
    logic                     neg_reg, neg_next;
    logic [GLYPH_W-1:0]       shade_reg, shade_next;
    logic signed [7:0]        ceil_reg, ceil_next;
    logic [ROW_W-1:0]         y_reg, y_next;

    logic signed [31:0]       mul_a, mul_b;
    logic signed [63:0]       prod_reg;

    logic [ANGLE_W-1:0]       ang;
    logic [10:0]              tt;
    logic [14:0]              z;
    logic [15:0]              sine_mag;
    logic signed [15:0]       sine_val;
    logic [DIST_W-1:0]        lim;
    logic [DIST_W-1:0]        d_here;
    logic [25:0]              adv_x, adv_y;
    logic [4:0]               cx, cy;
    logic signed [13:0]       vx, vy;
    logic signed [28:0]       cr;
    logic [28:0]              cr_abs;
    logic [56:0]              tot;
    logic                     aligned;
    logic                     wall;
    logic [3:0]               mx, my;
    logic signed [17:0]       diff;
    logic [16:0]              mag;
    logic [23:0]              den_sh;
    logic [QW-1:0]            qnew;
    logic [18:0]              dist4, dist3, dist2;
    logic signed [7:0]        yy, floor_row;
    logic [9:0]               rr;
    logic [GLYPH_W-1:0]       glyph_c;

    always_comb
    begin
        ang      = phase_reg ? job_reg.ray + 12'd1024 : job_reg.ray;
        tt       = ang[10] ? 11'd1024 - {1'b0, ang[9:0]} : {1'b0, ang[9:0]};
        z        = {tt, 4'b0000};
        sine_mag = prod_reg[29:14];
        sine_val = ang[11] ? -$signed(sine_mag) : $signed(sine_mag);
        lim      = DIST_W'(depth_limit) * DIST_W'(10);
        d_here   = {d10_reg, 8'b0};
        adv_x    = step_axis(nx_reg, rx_reg, ex_reg);
        adv_y    = step_axis(ny_reg, ry_reg, ey_reg);
        mx       = nx_reg[6] ? 4'd0 : nx_reg[3:0];
        my       = ny_reg[6] ? 4'd0 : ny_reg[3:0];
        wall     = map_bits[{mx, my}];
        cx       = {1'b0, cellx_reg} + {4'b0, k_reg[1]};
        cy       = {1'b0, celly_reg} + {4'b0, k_reg[0]};
        vx       = $signed({1'b0, cx, 8'b0}) - $signed({2'b0, job_reg.pos_x});
        vy       = $signed({1'b0, cy, 8'b0}) - $signed({2'b0, job_reg.pos_y});
        cr       = t1_reg - prod_reg[28:0];
        cr_abs   = cr[28] ? 29'(-cr) : 29'(cr);
        tot      = (57'(prod_reg[34:0]) << 21) + 57'(lo_reg);
        aligned  = (dot_reg > 29'sd0) && !big_reg && (58'(tot) < d2_reg);
        diff     = $signed({1'b0, dist_reg}) - 18'sd5120;
        mag      = diff[17] ? 17'(-diff) : 17'(diff);
        den_sh   = 24'(den_reg) << qi_reg;
        qnew     = quot_reg;
        if (rem_reg >= den_sh)
        begin
            qnew[qi_reg] = 1'b1;
        end
        dist4    = {dist_reg, 2'b00};
        dist3    = 19'(dist_reg) * 19'd3;
        dist2    = {1'b0, dist_reg, 1'b0};
    end

    // glyph for the current row
    always_comb
    begin
        yy        = $signed({2'b00, y_reg});
        floor_row = 8'(SCREEN_HEIGHT) - ceil_reg;
        rr        = 10'(SCREEN_HEIGHT) - 10'(y_reg);
        if (yy <= ceil_reg)
        begin
            glyph_c = GLYPH_BLANK;
        end
        else if (yy <= floor_row)
        begin
            glyph_c = shade_reg;
        end
        else if (8 * rr < 10'(SCREEN_HEIGHT))
        begin
            glyph_c = GLYPH_HASH;
        end
        else if (4 * rr < 10'(SCREEN_HEIGHT))
        begin
            glyph_c = GLYPH_X;
        end
        else if (8 * rr < 10'(3 * SCREEN_HEIGHT))
        begin
            glyph_c = GLYPH_DOT;
        end
        else if (20 * rr < 10'(9 * SCREEN_HEIGHT))
        begin
            glyph_c = GLYPH_DASH;
        end
        else
        begin
            glyph_c = GLYPH_BLANK;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        phase_next = phase_reg;
        z2_next    = z2_reg;
        ex_next    = ex_reg;
        ey_next    = ey_reg;
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        d10_next   = d10_reg;
        cellx_next = cellx_reg;
        celly_next = celly_reg;
        far_next   = far_reg;
        k_next     = k_reg;
        edge_next  = edge_reg;
        t1_next    = t1_reg;
        dot_next   = dot_reg;
        cra_next   = cra_reg;
        big_next   = big_reg;
        d2_next    = d2_reg;
        c2_next    = c2_reg;
        lo_next    = lo_reg;
        dist_next  = dist_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        qi_next    = qi_reg;
        quot_next  = quot_reg;
        neg_next   = neg_reg;
        shade_next = shade_reg;
        ceil_next  = ceil_reg;
        y_next     = y_reg;
        mul_a      = '0;
        mul_b      = '0;
        pop        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    job_next   = job;
                    phase_next = 1'b0;
                    state_next = S_SZ;
                end
            end
            S_SZ:
            begin
                mul_a      = 32'(z);
                mul_b      = 32'(z);
                state_next = S_SP;
            end
            S_SP:
            begin
                z2_next    = prod_reg[28:14];
                mul_a      = 32'(prod_reg[28:14]);
                mul_b      = 32'sd1231;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                mul_a      = 32'(z2_reg);
                mul_b      = 32'sd10583 - 32'(prod_reg[28:14]);
                state_next = S_SS;
            end
            S_SS:
            begin
                mul_a      = 32'(z);
                mul_b      = 32'sd25736 - 32'(prod_reg[28:14]);
                state_next = S_SE;
            end
            S_SE:
            begin
                if (!phase_reg)
                begin
                    ex_next    = sine_val;
                    phase_next = 1'b1;
                    state_next = S_SZ;
                end
                else
                begin
                    ey_next    = sine_val;
                    state_next = S_MINIT;
                end
            end
            S_MINIT:
            begin
                nx_next    = $signed({3'b000, job_reg.pos_x[11:8]});
                ny_next    = $signed({3'b000, job_reg.pos_y[11:8]});
                rx_next    = $signed(19'(job_reg.pos_x[7:0]) * 19'd640);
                ry_next    = $signed(19'(job_reg.pos_y[7:0]) * 19'd640);
                d10_next   = '0;
                edge_next  = 1'b0;
                state_next = S_MSTEP;
            end
            S_MSTEP:
            begin
                if (d10_reg < 9'd10 || d_here < lim)
                begin
                    {nx_next, rx_next} = adv_x;
                    {ny_next, ry_next} = adv_y;
                    d10_next = d10_reg + 1'b1;
                    if (d10_reg >= 9'd10)
                    begin
                        state_next = S_MCHK;
                    end
                end
                else
                begin
                    dist_next  = d_here;
                    state_next = S_DIV0;
                end
            end
            S_MCHK:
            begin
                if (off_map(nx_reg, rx_reg) || off_map(ny_reg, ry_reg))
                begin
                    dist_next  = lim;
                    state_next = S_DIV0;
                end
                else if (wall)
                begin
                    cellx_next = mx;
                    celly_next = my;
                    // farthest corner: per axis the far side, the later one on a tie
                    far_next   = {({mx, 8'd128} >= job_reg.pos_x),
                                  ({my, 8'd128} >= job_reg.pos_y)};
                    k_next     = 2'd0;
                    state_next = S_E0;
                end
                else
                begin
                    state_next = S_MSTEP;
                end
            end
            S_E0:
            begin
                if (k_reg == far_reg)
                begin
                    if (k_reg == 2'd3)
                    begin
                        dist_next  = d_here;
                        state_next = S_DIV0;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    mul_a      = 32'(ex_reg);
                    mul_b      = 32'(vx);
                    state_next = S_E1;
                end
            end
            S_E1:
            begin
                t1_next    = prod_reg[28:0];
                mul_a      = 32'(ey_reg);
                mul_b      = 32'(vy);
                state_next = S_E2;
            end
            S_E2:
            begin
                dot_next   = t1_reg + prod_reg[28:0];
                mul_a      = 32'(ex_reg);
                mul_b      = 32'(vy);
                state_next = S_E3;
            end
            S_E3:
            begin
                t1_next    = prod_reg[28:0];
                mul_a      = 32'(ey_reg);
                mul_b      = 32'(vx);
                state_next = S_E4;
            end
            S_E4:
            begin
                // |cross| at or above 2^21 can never pass the tan^2 test
                cra_next   = cr_abs[20:0];
                big_next   = (cr_abs[28:21] != '0);
                state_next = S_E5;
            end
            S_E5:
            begin
                mul_a      = 32'(dot_reg);
                mul_b      = 32'(dot_reg);
                state_next = S_E6;
            end
            S_E6:
            begin
                d2_next    = prod_reg[57:0];
                mul_a      = 32'(cra_reg);
                mul_b      = 32'(cra_reg);
                state_next = S_E7;
            end
            S_E7:
            begin
                c2_next    = prod_reg[41:0];
                mul_a      = 32'(prod_reg[20:0]);
                mul_b      = 32'sd9999;
                state_next = S_E8;
            end
            S_E8:
            begin
                lo_next    = prod_reg[34:0];
                mul_a      = 32'(c2_reg[41:21]);
                mul_b      = 32'sd9999;
                state_next = S_E9;
            end
            S_E9:
            begin
                edge_next = edge_reg || aligned;
                if (k_reg == 2'd3)
                begin
                    dist_next  = d_here;
                    state_next = S_DIV0;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_E0;
                end
            end
            S_DIV0:
            begin
                rem_next  = 24'(mag) * 24'(SCREEN_HEIGHT);
                den_next  = {dist_reg, 1'b0};
                neg_next  = diff[17];
                quot_next = '0;
                qi_next   = QI_W'(QW - 1);
                if (edge_reg)
                begin
                    shade_next = GLYPH_BLANK;
                end
                else if (dist4 <= 19'(lim))
                begin
                    shade_next = GLYPH_FULL;
                end
                else if (dist3 < 19'(lim))
                begin
                    shade_next = GLYPH_DARK;
                end
                else if (dist2 < 19'(lim))
                begin
                    shade_next = GLYPH_MEDIUM;
                end
                else if (dist_reg < lim)
                begin
                    shade_next = GLYPH_LIGHT;
                end
                else
                begin
                    shade_next = GLYPH_BLANK;
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                quot_next = qnew;
                if (rem_reg >= den_sh)
                begin
                    rem_next = rem_reg - den_sh;
                end
                if (qi_reg == '0)
                begin
                    ceil_next  = neg_reg ? -$signed(8'(qnew)) : $signed(8'(qnew));
                    y_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    qi_next = qi_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                if (raster.ready)
                begin
                    if (y_reg == ROW_W'(SCREEN_HEIGHT - 1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        job_reg   <= job_next;
        phase_reg <= phase_next;
        z2_reg    <= z2_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        nx_reg    <= nx_next;
        ny_reg    <= ny_next;
        rx_reg    <= rx_next;
        ry_reg    <= ry_next;
        d10_reg   <= d10_next;
        cellx_reg <= cellx_next;
        celly_reg <= celly_next;
        far_reg   <= far_next;
        k_reg     <= k_next;
        edge_reg  <= edge_next;
        t1_reg    <= t1_next;
        dot_reg   <= dot_next;
        cra_reg   <= cra_next;
        big_reg   <= big_next;
        d2_reg    <= d2_next;
        c2_reg    <= c2_next;
        lo_reg    <= lo_next;
        dist_reg  <= dist_next;
        rem_reg   <= rem_next;
        den_reg   <= den_next;
        qi_reg    <= qi_next;
        quot_reg  <= quot_next;
        neg_reg   <= neg_next;
        shade_reg <= shade_next;
        ceil_reg  <= ceil_next;
        y_reg     <= y_next;
    end

    assign raster.valid = (state_reg == S_EMIT);
    assign raster.row   = y_reg;
    assign raster.glyph = glyph_c;
    assign raster.last  = (y_reg == ROW_W'(SCREEN_HEIGHT - 1));

endmodule
